### rtl/core/nalps_pkg.sv
// ----------------------------------------------------------------------------
// nalps_pkg
// Shared types and constants for the length-prefix to start-code rewriter.
// ----------------------------------------------------------------------------
package nalps_pkg;

    // Bytes in one big-endian length prefix
    localparam int unsigned PREFIX_LEN  = 4;
    // Most bytes one input word can release
    localparam int unsigned MAX_OUT     = 5;
    // Output queue depth and pointer width
    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Start code bytes
    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // One output word: byte plus end-of-sample flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    // Count of words released by one input word (0..MAX_OUT)
    typedef logic [2:0] t_out_cnt;

endpackage

### rtl/core/nal_length_prefix_to_start_code.sv
// ----------------------------------------------------------------------------
// nal_length_prefix_to_start_code
// Rewrites 4-byte NAL length prefixes of a video sample into 00 00 00 01.
// ----------------------------------------------------------------------------
// Sustains one byte per cycle in and out while the queue has room. Each input
// word is registered, then decoded combinationally against the
// prefix/payload state and its 0 to 5 output bytes are pushed into a 16-entry
// output queue; the queue head drives the master side directly, so a released
// byte passes the input register and the queue before it shows on the output.
// A completed prefix and the byte after it release the start code plus that
// byte at once (a zero length mid-sample releases only the start code; the
// byte then opens the next prefix) after the prefix bytes gave no output, so
// the queue absorbs the burst and input stalls only while the queue holds
// more than 11 bytes, i.e. when the downstream side stalls. The four prefix
// bytes are held until the next byte of the sample shows whether to convert
// them; at the sample end they are flushed unchanged. A sample that already
// opens with a start code passes through untouched.
module nal_length_prefix_to_start_code (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave side
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // sample_end
    // Master side
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // out_last
);

    localparam int unsigned CW = nalps_pkg::QUEUE_AW + 1;
    localparam logic [CW-1:0] FILL_LIMIT =
        CW'(nalps_pkg::QUEUE_DEPTH - nalps_pkg::MAX_OUT);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // Conversion state
    logic [7:0]  r_held [nalps_pkg::PREFIX_LEN];
    logic [2:0]  r_held_count;
    logic [31:0] r_payload_left;
    logic        r_at_start;
    logic        r_pass;

    logic [7:0]  n_held [nalps_pkg::PREFIX_LEN];
    logic [2:0]  n_held_count;
    logic [31:0] n_payload_left;
    logic        n_at_start;
    logic        n_pass;

    // Output queue
    nalps_pkg::t_out_word r_queue [nalps_pkg::QUEUE_DEPTH];
    logic [nalps_pkg::QUEUE_AW-1:0] r_wptr;
    logic [nalps_pkg::QUEUE_AW-1:0] r_rptr;
    logic [CW-1:0]                  r_count;

    nalps_pkg::t_out_word w_emit [nalps_pkg::MAX_OUT];
    nalps_pkg::t_out_cnt  w_emit_cnt;
    logic                 w_fire;
    logic                 w_pop;
    logic                 w_in_acc;

    // Handshakes
    assign w_fire        = r_in_valid && (r_count <= FILL_LIMIT);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_queue[r_rptr].data;
    assign m_axis_tlast  = r_queue[r_rptr].last;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (w_in_acc) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Decode of one byte against the prefix/payload state
    always_comb begin
        logic [31:0] len;
        logic [2:0]  hc_new;
        n_held         = r_held;
        n_held_count   = r_held_count;
        n_payload_left = r_payload_left;
        n_at_start     = r_at_start;
        n_pass         = r_pass;
        w_emit_cnt     = '0;
        len    = {r_held[0], r_held[1], r_held[2], r_held[3]};
        hc_new = r_held_count + 3'd1;
        for (int i = 0; i < nalps_pkg::MAX_OUT; i++) begin
            w_emit[i].data = r_in_data;
            w_emit[i].last = 1'b0;
        end

        if (r_pass) begin
            w_emit_cnt = 3'd1;
        end else if (r_payload_left != '0) begin
            w_emit_cnt     = 3'd1;
            n_payload_left = r_payload_left - 32'd1;
        end else if (r_held_count[2]) begin
            // full prefix followed by a byte: emit start code
            w_emit[0].data = nalps_pkg::SC_ZERO;
            w_emit[1].data = nalps_pkg::SC_ZERO;
            w_emit[2].data = nalps_pkg::SC_ZERO;
            w_emit[3].data = nalps_pkg::SC_ONE;
            if (len == '0) begin
                // zero length: this byte opens the next prefix
                n_held[0]    = r_in_data;
                n_held_count = 3'd1;
                w_emit_cnt   = r_in_last ? 3'd5 : 3'd4;
            end else begin
                n_held_count   = '0;
                n_payload_left = len - 32'd1;
                w_emit_cnt     = 3'd5;
            end
        end else begin
            // collect prefix byte
            n_held[r_held_count[1:0]] = r_in_data;
            n_held_count              = hc_new;
            if (hc_new[2] && r_at_start) begin
                n_at_start = 1'b0;
                if (n_held[0] == nalps_pkg::SC_ZERO && n_held[1] == nalps_pkg::SC_ZERO &&
                    n_held[2] == nalps_pkg::SC_ZERO && n_held[3] == nalps_pkg::SC_ONE) begin
                    n_pass       = 1'b1;
                    n_held_count = '0;
                    w_emit_cnt   = 3'd4;
                    for (int i = 0; i < nalps_pkg::PREFIX_LEN; i++) begin
                        w_emit[i].data = n_held[i];
                    end
                end
            end
            // sample ends inside the prefix: flush held bytes unchanged
            if (r_in_last && n_held_count != '0) begin
                w_emit_cnt = n_held_count;
                for (int i = 0; i < nalps_pkg::PREFIX_LEN; i++) begin
                    w_emit[i].data = n_held[i];
                end
            end
        end

        // sample end: flag final byte, return to start-of-sample state
        if (r_in_last) begin
            for (int i = 0; i < nalps_pkg::MAX_OUT; i++) begin
                if (3'(i + 1) == w_emit_cnt) begin
                    w_emit[i].last = 1'b1;
                end
            end
            n_held_count   = '0;
            n_payload_left = '0;
            n_at_start     = 1'b1;
            n_pass         = 1'b0;
        end
    end

    // Conversion state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count   <= '0;
            r_payload_left <= '0;
            r_at_start     <= 1'b1;
            r_pass         <= 1'b0;
        end else if (w_fire) begin
            r_held_count   <= n_held_count;
            r_payload_left <= n_payload_left;
            r_at_start     <= n_at_start;
            r_pass         <= n_pass;
        end
        if (w_fire) begin
            r_held <= n_held;
        end
    end

    // Output queue storage
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            for (int k = 0; k < nalps_pkg::MAX_OUT; k++) begin
                if (3'(k) < w_emit_cnt) begin
                    r_queue[r_wptr + nalps_pkg::QUEUE_AW'(k)] <= w_emit[k];
                end
            end
        end
    end

    // Output queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_fire) begin
                r_wptr <= r_wptr + nalps_pkg::QUEUE_AW'(w_emit_cnt);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + nalps_pkg::QUEUE_AW'(1);
            end
            r_count <= r_count
                     + (w_fire ? CW'(w_emit_cnt) : CW'(0))
                     - (w_pop ? CW'(1) : CW'(0));
        end
    end

endmodule
